// ===== sv/smv_pkg.sv =====
package smv_pkg;

  localparam int VEC_DEPTH = 1024;
  localparam int VEC_AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW = $clog2(OUTQ_DEPTH);

  typedef enum logic [1:0] {
    OP_VEC_WRITE = 2'd0,
    OP_NONZERO   = 2'd1,
    OP_END_ROW   = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [9:0]         index;
    logic signed [31:0] value;
  } smv_in_t;

  typedef struct packed {
    logic [15:0]        row_index;
    logic signed [31:0] row_sum;
  } smv_out_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    op_e               op;
    logic              hit;
    logic [VEC_AW-1:0] addr;
    logic [31:0]       value;
  } smv_cmd_t;

endpackage

// ===== sv/smv_front.sv =====
module smv_front import smv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  smv_in_t  item_i,
  input  logic     clr_busy_i,
  output logic     cmd_valid_o,
  output smv_cmd_t cmd_o,
  input  logic     cmd_pop_i
);

  smv_cmd_t           entries_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_AW:0]   cnt_q, cnt_d;

  logic        keep;
  logic        accept;
  logic        enq;
  logic        deq;
  logic [31:0] idx_ext;
  smv_cmd_t    cmd_new;

  assign idx_ext = 32'(item_i.index);

  always_comb begin
    case (item_i.op)
      OP_VEC_WRITE: keep = 1'b1;
      OP_NONZERO:   keep = 1'b1;
      OP_END_ROW:   keep = 1'b1;
      default:      keep = 1'b0;
    endcase
  end

  always_comb begin
    cmd_new.op    = op_e'(item_i.op);
    cmd_new.hit   = idx_ext < 32'(VEC_DEPTH);
    cmd_new.addr  = idx_ext[VEC_AW-1:0];
    cmd_new.value = item_i.value;
  end

  // Hold off the producer while the command queue is full or the vector store is being cleared.
  assign full   = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH)) | clr_busy_i;
  assign accept = push & ~full;
  // Drop unused op codes here; they never reach the back end.
  assign enq    = accept & keep;
  assign deq    = cmd_pop_i & (cnt_q != '0);

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = enq ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = deq ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!enq && deq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      entries_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== sv/smv_back.sv =====
module smv_back import smv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  smv_cmd_t cmd_i,
  output logic     cmd_pop_o,
  output logic     clr_busy_o,
  output logic     empty,
  input  logic     pop,
  output smv_out_t result_o
);

  // Vector store and its clearing sweep
  logic [31:0]       vec_mem [VEC_DEPTH];
  logic [31:0]       rdata_q;
  logic              clr_busy_q;
  logic [VEC_AW-1:0] clr_addr_q;

  // Pipeline stages
  logic        s1_v_q;
  op_e         s1_op_q;
  logic        s1_hit_q;
  logic [31:0] s1_value_q;
  logic        s2_v_q;
  op_e         s2_op_q;
  logic [31:0] s2_prod_q;
  logic [31:0] prod_lo;

  // Row state
  logic [31:0] acc_q, acc_d;
  logic [15:0] row_cnt_q, row_cnt_d;

  // Result queue
  smv_out_t           outq_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] out_wr_q, out_rd_q;
  logic [OUTQ_AW:0]   out_cnt_q, out_cnt_d;
  logic [OUTQ_AW+1:0] inflight;
  logic               out_push;
  logic               out_pop;
  logic               issue;
  smv_out_t           out_new;

  assign clr_busy_o = clr_busy_q;

  // Reserve a result slot for every item still in the pipe.
  assign inflight  = (OUTQ_AW+2)'(out_cnt_q) + (OUTQ_AW+2)'(s1_v_q)
                   + (OUTQ_AW+2)'(s2_v_q);
  assign issue     = cmd_valid_i & ~clr_busy_q & (inflight < (OUTQ_AW+2)'(OUTQ_DEPTH));
  assign cmd_pop_o = issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == VEC_AW'(VEC_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Write and read at the same stage so a read sees every earlier write.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      vec_mem[clr_addr_q] <= '0;
    end else if (issue && cmd_i.op == OP_VEC_WRITE && cmd_i.hit) begin
      vec_mem[cmd_i.addr] <= cmd_i.value;
    end
    if (issue) begin
      rdata_q <= vec_mem[cmd_i.addr];
    end
  end

  assign prod_lo = s1_value_q * rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_op_q    <= cmd_i.op;
      s1_hit_q   <= cmd_i.hit;
      s1_value_q <= cmd_i.value;
    end
    if (s1_v_q) begin
      s2_op_q   <= s1_op_q;
      s2_prod_q <= s1_hit_q ? prod_lo : '0;
    end
  end

  always_comb begin
    acc_d     = acc_q;
    row_cnt_d = row_cnt_q;
    out_push  = 1'b0;
    out_new.row_index = row_cnt_q;
    out_new.row_sum   = acc_q;
    if (s2_v_q) begin
      case (s2_op_q)
        OP_VEC_WRITE: begin
          row_cnt_d = '0;
        end
        OP_NONZERO: begin
          acc_d = acc_q + s2_prod_q;
        end
        OP_END_ROW: begin
          out_push  = 1'b1;
          acc_d     = '0;
          row_cnt_d = row_cnt_q + 1'b1;
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      row_cnt_q <= '0;
    end else begin
      acc_q     <= acc_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  assign empty    = (out_cnt_q == '0);
  assign out_pop  = pop & ~empty;
  assign result_o = outq_q[out_rd_q];

  always_comb begin
    out_cnt_d = out_cnt_q;
    if (out_push && !out_pop) begin
      out_cnt_d = out_cnt_q + 1'b1;
    end else if (!out_push && out_pop) begin
      out_cnt_d = out_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (out_push) begin
        out_wr_q <= out_wr_q + 1'b1;
      end
      if (out_pop) begin
        out_rd_q <= out_rd_q + 1'b1;
      end
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      outq_q[out_wr_q] <= out_new;
    end
  end

endmodule

// ===== sv/sparse_matrix_vector_multiply_unit.sv =====
// Sparse matrix times dense vector, matrix rows streamed in compressed-row order.
// Input channel (push/full, item_i): op 0 writes vector element index with value and
// restarts the row count, op 1 multiplies value by the vector element at column index
// and adds it to the running row sum, op 2 ends the row; op 3 is ignored.
// Result channel (empty/pop, result_o): one transaction per end of row, carrying the
// row number (from zero, wraps at 16 bits) and the row sum wrapped to 32 bits.
// Throughput: one transaction per cycle in both directions while the receiver keeps popping.
// A result reaches the result port once its end-of-row transaction has passed the
// command queue, memory read, multiply and accumulate steps.
// The 32x32 multiply and the single-port read of the vector memory set the pipe depth.
// After reset, full stays high while the vector memory is swept to zero.
// When the receiver stops popping, results wait in a 4-entry result queue; the back end
// then stops issuing and a 4-entry command queue fills before full is raised.
module sparse_matrix_vector_multiply_unit import smv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  smv_in_t  item_i,
  output logic     empty,
  input  logic     pop,
  output smv_out_t result_o
);

  logic     cmd_valid;
  smv_cmd_t cmd;
  logic     cmd_pop;
  logic     clr_busy;

  smv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .clr_busy_i  (clr_busy),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  smv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .clr_busy_o  (clr_busy),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule

// ===== sv/smv_checker.sv =====
module smv_checker import smv_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     push,
  input logic     full,
  input smv_in_t  item_i,
  input logic     empty,
  input logic     pop,
  input smv_out_t result_o
);

  // Reset leaves no result and blocks input while the vector memory is cleared.
  a_reset_state: assert property (@(posedge clk_i) !rst_ni |=> full && empty)
    else $error("block not blocked and empty after reset");

  // A waiting result holds until it is taken.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("waiting result changed or vanished");

  // The result queue only drains through pops.
  a_drain_by_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("result queue emptied without a pop");

  // A waiting result carries no unknown bits.
  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !$isunknown(result_o))
    else $error("waiting result holds unknown bits");

endmodule

bind sparse_matrix_vector_multiply_unit smv_checker u_smv_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .item_i   (item_i),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

// ===== tb/smv_row_checker.sv =====
module smv_row_checker import smv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  logic     full_i,
  input  smv_in_t  item_i,
  input  logic     empty_i,
  input  logic     pop_i,
  input  smv_out_t result_i,
  output int       errors_o,
  output int       waiting_o,
  output int       rows_checked_o
);

  // Shadow copy of the block's state
  logic [31:0] vec_copy [VEC_DEPTH];
  logic [31:0] row_acc;
  logic [15:0] row_num;

  smv_out_t expected_rows [$];

  int fail_count = 0;
  int row_waiting = 0;
  int rows_seen = 0;

  assign errors_o       = fail_count;
  assign waiting_o      = row_waiting;
  assign rows_checked_o = rows_seen;

  task automatic track_item(input smv_in_t it);
    logic [31:0] elem;
    smv_out_t    row;
    elem = '0;
    case (it.op)
      OP_VEC_WRITE: begin
        if (it.index < VEC_DEPTH) vec_copy[it.index] = it.value;
        row_num = '0;
      end
      OP_NONZERO: begin
        if (it.index < VEC_DEPTH) elem = vec_copy[it.index];
        // keep only the low 32 bits of product and sum
        row_acc = row_acc + 32'(it.value) * elem;
      end
      OP_END_ROW: begin
        row.row_index = row_num;
        row.row_sum   = row_acc;
        expected_rows.push_back(row);
        row_acc = '0;
        row_num = row_num + 16'd1;
      end
      default: ;  // unused op: drop
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    smv_out_t want;
    if (!rst_ni) begin
      foreach (vec_copy[i]) vec_copy[i] = '0;
      row_acc = '0;
      row_num = '0;
      expected_rows.delete();
    end else begin
      if (push_i && !full_i) track_item(item_i);
      if (pop_i && !empty_i) begin
        rows_seen++;
        if (expected_rows.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got row %0d sum %0d",
                   $time, result_i.row_index, result_i.row_sum);
        end else begin
          want = expected_rows.pop_front();
          if (result_i.row_index !== want.row_index) begin
            fail_count++;
            $display("%0t: row_index expected %0d, got %0d",
                     $time, want.row_index, result_i.row_index);
          end
          if (result_i.row_sum !== want.row_sum) begin
            fail_count++;
            $display("%0t: row_sum of row %0d expected %0d, got %0d",
                     $time, want.row_index, want.row_sum, result_i.row_sum);
          end
        end
      end
    end
    row_waiting = expected_rows.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import smv_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         RAND_ITEMS = 1350;
  localparam int         HOLD_CYCLES = 300;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     push   = 1'b0;
  logic     full;
  smv_in_t  item_i = '0;
  logic     empty;
  logic     pop    = 1'b0;
  smv_out_t result_o;

  int errors;
  int waiting;
  int rows_checked;

  int items_sent   = 0;
  int unused_sent  = 0;
  int burst_left   = 0;
  bit random_started = 1'b0;

  sparse_matrix_vector_multiply_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  smv_row_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .item_i         (item_i),
    .empty_i        (empty),
    .pop_i          (pop),
    .result_i       (result_o),
    .errors_o       (errors),
    .waiting_o      (waiting),
    .rows_checked_o (rows_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'($urandom_range(0, 15));
      4: return 32'd0 - 32'($urandom_range(1, 16));
      default: return $urandom();
    endcase
  endfunction

  // Offer one transaction; open a new burst, often with a gap first, when the old one runs out.
  task automatic send_item(input logic [1:0] op, input logic [9:0] idx,
                           input logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push         <= 1'b1;
    item_i.op    <= op;
    item_i.index <= idx;
    item_i.value <= val;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (op == OP_UNUSED) unused_sent++;
    else items_sent++;
  endtask

  // Receiver: random stall modes, plus one long hold-off once random traffic runs.
  initial begin
    int mode;
    int span;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (random_started && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(8, 64);
      repeat (span) begin
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int target;
    int base;
    int nwr;
    int nrows;
    int nnz;
    logic [9:0] col;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty rows, unwritten columns, extreme values, wrap of product and sum,
    // unused op, vector write inside a row.
    send_item(OP_END_ROW,   10'd0,    32'h0);
    send_item(OP_NONZERO,   10'd5,    32'h7FFF_FFFF);
    send_item(OP_END_ROW,   10'd0,    32'h0);
    send_item(OP_VEC_WRITE, 10'd0,    32'h7FFF_FFFF);
    send_item(OP_VEC_WRITE, 10'd1023, 32'h8000_0000);
    send_item(OP_VEC_WRITE, 10'd1,    32'hFFFF_FFFF);
    send_item(OP_NONZERO,   10'd0,    32'h7FFF_FFFF);
    send_item(OP_NONZERO,   10'd1023, 32'h8000_0000);
    send_item(OP_NONZERO,   10'd1,    32'hFFFF_FFFF);
    send_item(OP_NONZERO,   10'd1,    32'h8000_0000);
    send_item(OP_END_ROW,   10'd1023, 32'hFFFF_FFFF);
    send_item(OP_UNUSED,    10'd1023, 32'hFFFF_FFFF);
    send_item(OP_NONZERO,   10'd0,    32'h2);
    send_item(OP_VEC_WRITE, 10'd2,    32'h3);
    send_item(OP_NONZERO,   10'd2,    32'h7FFF_FFFF);
    send_item(OP_UNUSED,    10'd0,    32'h0);
    send_item(OP_END_ROW,   10'd0,    32'h0);
    send_item(OP_END_ROW,   10'd0,    32'h0);
    send_item(OP_NONZERO,   10'd1023, 32'h0);
    send_item(OP_END_ROW,   10'd0,    32'h0);

    // Random: vector segments followed by short rows over columns mostly near the segment
    random_started = 1'b1;
    target = items_sent + RAND_ITEMS;
    while (items_sent < target) begin
      base = $urandom_range(0, 1023 - 31);
      nwr  = $urandom_range(1, 12);
      repeat (nwr) send_item(OP_VEC_WRITE, 10'(base + $urandom_range(0, 31)), pick_value());
      nrows = $urandom_range(1, 8);
      repeat (nrows) begin
        nnz = $urandom_range(0, 6);
        repeat (nnz) begin
          if ($urandom_range(0, 19) == 0)
            send_item(OP_UNUSED, 10'($urandom()), $urandom());
          if ($urandom_range(0, 29) == 0)
            send_item(OP_VEC_WRITE, 10'(base + $urandom_range(0, 31)), pick_value());
          if ($urandom_range(0, 7) == 0) col = 10'($urandom());
          else col = 10'(base + $urandom_range(0, 31));
          send_item(OP_NONZERO, col, pick_value());
        end
        // now and then leave a row open so it merges into the next one
        if ($urandom_range(0, 15) != 0)
          send_item(OP_END_ROW, 10'($urandom()), $urandom());
      end
    end

    push <= 1'b0;
    while (waiting != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d transactions plus %0d with the unused op code.",
             items_sent, unused_sent);
    $display("Checked %0d row results over corner values, empty rows and random rows.",
             rows_checked);
    if (errors == 0 && waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
